>>> src/mbe_pkg.sv
// ============================================================================
// mbe_pkg: shared types and constants of the Mandelbrot escape-time block
// Fixed-point formats, configuration register indexes, multiplier shift
// codes and the saturating adder used by the iteration datapath.
// ============================================================================
`default_nettype none

package mbe_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 60;
  localparam int ITER_BITS    = 12;
  localparam int DATA_BITS    = 64;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [DATA_BITS-1:0] fix_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RE_ORIGIN   = 3'd0,
    CFG_RE_STEP     = 3'd1,
    CFG_IM_ORIGIN   = 3'd2,
    CFG_IM_STEP     = 3'd3,
    CFG_ROUND_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SH_NONE   = 2'd0,
    SH_DOUBLE = 2'd1,
    SH_FRAC   = 2'd2
  } mul_shift_e;

  typedef struct packed {
    fix_t                 re_origin;
    fix_t                 re_step;
    fix_t                 im_origin;
    fix_t                 im_step;
    logic [ITER_BITS-1:0] round_limit;
  } mbe_cfg_t;

  localparam fix_t S64_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
  localparam fix_t S64_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};

  localparam fix_t ESC_LIMIT    = fix_t'(64'd4 << FRAC_BITS);
  localparam fix_t START_RESET  = fix_t'(64'd0 - (64'd2 << FRAC_BITS));
  localparam fix_t STEP_RESET   = '0;
  localparam logic [ITER_BITS-1:0] ROUND_LIMIT_RESET = ITER_BITS'(500);

  function automatic fix_t add_sat(fix_t a, fix_t b);
    logic signed [DATA_BITS:0] sum;
    sum = {a[DATA_BITS-1], a} + {b[DATA_BITS-1], b};
    if (sum[DATA_BITS] != sum[DATA_BITS-1]) begin
      return sum[DATA_BITS] ? S64_MIN : S64_MAX;
    end
    return fix_t'(sum[DATA_BITS-1:0]);
  endfunction

endpackage

`default_nettype wire

>>> src/mbe_if.sv
// ============================================================================
// mbe_if: pixel and result channel interfaces
// Valid/ready channels; a transaction completes when valid and ready are
// both high at a rising clock edge.
// ============================================================================
`default_nettype none

interface mbe_in_if import mbe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface mbe_out_if import mbe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ITER_BITS-1:0] escape_round;
  logic                 inside_res;

  modport source (output valid, output escape_round, output inside_res, input ready);
  modport sink   (input valid, input escape_round, input inside_res, output ready);
endinterface

`default_nettype wire

>>> src/mbe_cfg_regs.sv
// ============================================================================
// mbe_cfg_regs: configuration register file
// Holds the plane origin, per-pixel steps and the round budget. Writes to
// an unknown index are dropped.
// ============================================================================
`default_nettype none

module mbe_cfg_regs import mbe_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [DATA_BITS-1:0]    cfg_data_i,
  output mbe_cfg_t                     cfg_o
);

  mbe_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.re_origin   <= START_RESET;
      cfg_q.re_step     <= STEP_RESET;
      cfg_q.im_origin   <= START_RESET;
      cfg_q.im_step     <= STEP_RESET;
      cfg_q.round_limit <= ROUND_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RE_ORIGIN:   cfg_q.re_origin   <= fix_t'(cfg_data_i);
        CFG_RE_STEP:     cfg_q.re_step     <= fix_t'(cfg_data_i);
        CFG_IM_ORIGIN:   cfg_q.im_origin   <= fix_t'(cfg_data_i);
        CFG_IM_STEP:     cfg_q.im_step     <= fix_t'(cfg_data_i);
        CFG_ROUND_LIMIT: cfg_q.round_limit <= cfg_data_i[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> src/mbe_mul_unit.sv
// ============================================================================
// mbe_mul_unit: shared saturating fixed-point multiplier
// Multiplies two signed 64-bit operands through one 32x32 multiplier, four
// partial products accumulated into a 128-bit sum, then shifts the magnitude
// and saturates to the signed 64-bit range.
// ============================================================================
`default_nettype none

module mbe_mul_unit import mbe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire fix_t       a_i,
  input  wire fix_t       b_i,
  input  wire mul_shift_e shift_i,
  output logic            done_o,
  output fix_t            res_o
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_SAT
  } mstate_e;

  localparam logic [2:0] PP_DONE = 3'd4;

  mstate_e    state_q;
  logic [2:0] cnt_q;
  logic       pv_q;
  logic       done_q;
  fix_t       res_q;

  logic [DATA_BITS-1:0]   mag_a_q, mag_b_q;
  logic                   neg_q;
  mul_shift_e             sh_q;
  logic [DATA_BITS-1:0]   prod_q;
  logic [1:0]             pidx_q;
  logic [2*DATA_BITS-1:0] acc_q;

  logic [DATA_BITS-1:0]   a_u, b_u, mag_a, mag_b;
  logic [31:0]            a_limb, b_limb;
  logic [DATA_BITS-1:0]   prod_d;
  logic [2*DATA_BITS-1:0] pp_aligned, shifted;
  logic [DATA_BITS-1:0]   lo;
  logic                   ovf;
  fix_t                   sat_res;

  assign a_u   = a_i;
  assign b_u   = b_i;
  assign mag_a = a_u[DATA_BITS-1] ? (64'd0 - a_u) : a_u;
  assign mag_b = b_u[DATA_BITS-1] ? (64'd0 - b_u) : b_u;

  assign a_limb = cnt_q[0] ? mag_a_q[63:32] : mag_a_q[31:0];
  assign b_limb = cnt_q[1] ? mag_b_q[63:32] : mag_b_q[31:0];
  assign prod_d = a_limb * b_limb;

  always_comb begin
    case (pidx_q)
      2'd0:    pp_aligned = {64'd0, prod_q};
      2'd3:    pp_aligned = {prod_q, 64'd0};
      default: pp_aligned = {32'd0, prod_q, 32'd0};
    endcase
  end

  always_comb begin
    case (sh_q)
      SH_NONE:   shifted = acc_q;
      SH_DOUBLE: shifted = acc_q >> (FRAC_BITS - 1);
      SH_FRAC:   shifted = acc_q >> FRAC_BITS;
      default:   shifted = acc_q;
    endcase
  end

  assign lo  = shifted[DATA_BITS-1:0];
  assign ovf = (|shifted[2*DATA_BITS-1:DATA_BITS]) || lo[DATA_BITS-1];

  always_comb begin
    if (neg_q) begin
      sat_res = ovf ? S64_MIN : fix_t'(64'd0 - lo);
    end else begin
      sat_res = ovf ? S64_MAX : fix_t'(lo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= (state_q == M_SAT);
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            cnt_q   <= '0;
            pv_q    <= 1'b0;
            state_q <= M_RUN;
          end
        end
        M_RUN: begin
          if (cnt_q != PP_DONE) begin
            pv_q  <= 1'b1;
            cnt_q <= cnt_q + 3'd1;
          end else begin
            pv_q    <= 1'b0;
            state_q <= M_SAT;
          end
        end
        M_SAT: begin
          res_q   <= sat_res;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && start_i) begin
      mag_a_q <= mag_a;
      mag_b_q <= mag_b;
      neg_q   <= a_i[DATA_BITS-1] ^ b_i[DATA_BITS-1];
      sh_q    <= shift_i;
      acc_q   <= '0;
    end else if (state_q == M_RUN) begin
      if (pv_q) begin
        acc_q <= acc_q + pp_aligned;
      end
      if (cnt_q != PP_DONE) begin
        prod_q <= prod_d;
        pidx_q <= cnt_q[1:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> src/mandelbrot_escape_time.sv
// ============================================================================
// mandelbrot_escape_time: escape-time iteration for one pixel
// Maps a pixel to a point c of the complex plane and iterates z = z*z + c
// in signed fixed point until |z|^2 exceeds four or the round budget ends.
// ============================================================================
//
//   Channel   Dir  Payload                     Transaction
//   pixel_i   in   column, row                 valid && ready
//   result_o  out  escape_round, inside_res    valid && ready
//   cfg       in   cfg_idx_i, cfg_data_i       cfg_we_i
//
// Each 64-bit product is formed on the shared 32x32 multiplier, a round
// takes three products and each pixel adds the two coordinate products.
// A result turns valid when its pixel escapes in a round, or when the
// budget runs out while it stays inside; pixel_i is ready again in the same
// cycle as the result. Reset restores the register defaults.
// A finished pixel waits while an earlier result is still stalled on result_o.
// ============================================================================
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [DATA_BITS-1:0]    cfg_data_i,
  mbe_in_if.sink                       pixel_i,
  mbe_out_if.source                    result_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CX,
    S_CY,
    S_XY,
    S_XX,
    S_YY,
    S_OUT
  } state_e;

  mbe_cfg_t cfg;

  state_e                state_q;
  logic                  mul_start_q;
  fix_t                  mul_a_q, mul_b_q;
  mul_shift_e            mul_sh_q;
  logic [COORD_BITS-1:0] row_q;
  fix_t                  cx_q, cy_q, x_q, y_q, x2_q, y2_q;
  logic [ITER_BITS-1:0]  round_q;
  logic                  inside_q;
  logic                  out_valid_q;
  logic [ITER_BITS-1:0]  out_round_q;
  logic                  out_inside_q;

  logic mul_done;
  fix_t mul_res;
  fix_t y_new, x_new, mag2;
  logic escaped;
  logic last_round;
  logic mul_issue;
  logic out_load;

  mbe_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  mbe_mul_unit u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .shift_i(mul_sh_q),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign y_new      = add_sat(mul_res, cy_q);
  assign x_new      = add_sat(x2_q - y2_q, cx_q);
  assign mag2       = add_sat(x2_q, mul_res);
  assign escaped    = mag2 > ESC_LIMIT;
  assign last_round = (round_q == cfg.round_limit - ITER_BITS'(1));
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || result_o.ready);

  always_comb begin
    case (state_q)
      S_IDLE:           mul_issue = pixel_i.valid;
      S_CX, S_XY, S_XX: mul_issue = mul_done;
      S_CY:             mul_issue = mul_done && (cfg.round_limit != '0);
      S_YY:             mul_issue = mul_done && !escaped && !last_round;
      default:          mul_issue = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mul_start_q  <= 1'b0;
      mul_a_q      <= '0;
      mul_b_q      <= '0;
      mul_sh_q     <= SH_NONE;
      row_q        <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      x_q          <= '0;
      y_q          <= '0;
      x2_q         <= '0;
      y2_q         <= '0;
      round_q      <= '0;
      inside_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_round_q  <= '0;
      out_inside_q <= 1'b0;
    end else begin
      mul_start_q <= mul_issue;
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_round_q  <= inside_q ? '0 : round_q;
        out_inside_q <= inside_q;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pixel_i.valid) begin
            row_q    <= pixel_i.row;
            x_q      <= '0;
            y_q      <= '0;
            x2_q     <= '0;
            y2_q     <= '0;
            round_q  <= '0;
            mul_a_q  <= fix_t'({{(DATA_BITS-COORD_BITS){1'b0}}, pixel_i.column});
            mul_b_q  <= cfg.re_step;
            mul_sh_q <= SH_NONE;
            state_q  <= S_CX;
          end
        end
        S_CX: begin
          if (mul_done) begin
            cx_q     <= add_sat(cfg.re_origin, mul_res);
            mul_a_q  <= fix_t'({{(DATA_BITS-COORD_BITS){1'b0}}, row_q});
            mul_b_q  <= cfg.im_step;
            mul_sh_q <= SH_NONE;
            state_q  <= S_CY;
          end
        end
        S_CY: begin
          if (mul_done) begin
            cy_q <= add_sat(cfg.im_origin, mul_res);
            if (cfg.round_limit == '0) begin
              inside_q <= 1'b1;
              state_q  <= S_OUT;
            end else begin
              mul_a_q  <= x_q;
              mul_b_q  <= y_q;
              mul_sh_q <= SH_DOUBLE;
              state_q  <= S_XY;
            end
          end
        end
        S_XY: begin
          if (mul_done) begin
            y_q      <= y_new;
            x_q      <= x_new;
            mul_a_q  <= x_new;
            mul_b_q  <= x_new;
            mul_sh_q <= SH_FRAC;
            state_q  <= S_XX;
          end
        end
        S_XX: begin
          if (mul_done) begin
            x2_q     <= mul_res;
            mul_a_q  <= y_q;
            mul_b_q  <= y_q;
            mul_sh_q <= SH_FRAC;
            state_q  <= S_YY;
          end
        end
        S_YY: begin
          if (mul_done) begin
            y2_q <= mul_res;
            if (escaped) begin
              inside_q <= 1'b0;
              state_q  <= S_OUT;
            end else if (last_round) begin
              inside_q <= 1'b1;
              state_q  <= S_OUT;
            end else begin
              round_q  <= round_q + ITER_BITS'(1);
              mul_a_q  <= x_q;
              mul_b_q  <= y_q;
              mul_sh_q <= SH_DOUBLE;
              state_q  <= S_XY;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pixel_i.ready         = (state_q == S_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.escape_round = out_round_q;
  assign result_o.inside_res   = out_inside_q;

endmodule

`default_nettype wire

>>> src/mbe_checker.sv
// ============================================================================
// mbe_checker: port-level checks of the escape-time block
// Watches the pixel and result channels and is bound to the top level.
// ============================================================================
`default_nettype none

module mbe_checker import mbe_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [ITER_BITS-1:0] out_round_i,
  input wire logic                 out_inside_i
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i ##1 !in_ready_i)
    else $error("pixel channel ready while a pixel is being iterated");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a pixel in flight");

  a_inside_round_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_inside_i) |-> (out_round_i == '0))
    else $error("inside result carries a nonzero round");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_round_i) && $stable(out_inside_i)))
    else $error("stalled result changed");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pixel_i.valid),
  .in_ready_i  (pixel_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_round_i (result_o.escape_round),
  .out_inside_i(result_o.inside_res)
);

`default_nettype wire
